FILE: rtl/sosc_pkg.sv
// ----------------------------------------------------------------------------
// sosc_pkg: shared types and constants of the sine oscillator
// Widths, register indexes and the structs passed between the parts.
// ----------------------------------------------------------------------------
`default_nettype none

package sosc_pkg;

  // fixed-point widths
  localparam int TableAddrBits = 10;
  localparam int TableSize     = 1 << TableAddrBits;
  localparam int SampleBits    = 16;
  localparam int PhaseBits     = 32;
  localparam int GainBits      = 16;
  localparam int GainUseBits   = GainBits + 1;
  localparam int RampBits      = 16;
  localparam int GainOne       = 32768;

  // register port
  localparam int ApbAddrBits   = 4;
  localparam int ApbDataBits   = 32;

  // queue between front and back
  localparam int QueueDepth    = 2;
  localparam int QueuePtrBits  = $clog2(QueueDepth);
  localparam int QueueCntBits  = $clog2(QueueDepth + 1);

  // register indexes (word address)
  typedef enum logic [1:0] {
    REG_PHASE_INC   = 2'd0,
    REG_TARGET_GAIN = 2'd1,
    REG_RAMP_LENGTH = 2'd2
  } reg_idx_e;

  // register port request
  typedef struct packed {
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ApbAddrBits-1:0] paddr;
    logic [ApbDataBits-1:0] pwdata;
  } apb_req_t;

  // classified lookup: mirrored table index and sign of the half-wave
  typedef struct packed {
    logic                     neg;
    logic [TableAddrBits-1:0] idx;
  } lookup_t;

  // gain for one sample, Q1.15 rounded, and ramp status
  typedef struct packed {
    logic [GainUseBits-1:0] gain;
    logic                   active;
  } gain_t;

endpackage

`default_nettype wire

FILE: rtl/sosc_front.sv
// ----------------------------------------------------------------------------
// sosc_front: phase accumulator and lookup classification
// Takes one beat per cycle while the queue has room and no division runs,
// forms phase plus offset, pushes the quadrant-folded index into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sosc_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic signed [sosc_pkg::PhaseBits-1:0] fm_offset_i,
  output logic                                  in_stall_o,
  input  wire logic [sosc_pkg::PhaseBits-1:0]   phase_inc_i,
  input  wire logic                             busy_i,
  input  wire logic                             q_full_i,
  output logic                                  push_o,
  output sosc_pkg::lookup_t                     push_data_o
);
  import sosc_pkg::*;

  logic [PhaseBits-1:0]     phase_q, phase_d;
  logic [PhaseBits-1:0]     addr;
  logic [TableAddrBits-1:0] raw_idx;

  // accept when queue has room and no step division is running
  assign in_stall_o = q_full_i | busy_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  // lookup phase and quadrant folding
  assign addr             = phase_q + $unsigned(fm_offset_i);
  assign raw_idx          = addr[PhaseBits-3 -: TableAddrBits];
  assign push_data_o.neg  = addr[PhaseBits-1];
  assign push_data_o.idx  = addr[PhaseBits-2] ? ~raw_idx : raw_idx;

  // accumulator advances once per accepted beat
  assign phase_d = push_o ? phase_q + phase_inc_i : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sosc_queue.sv
// ----------------------------------------------------------------------------
// sosc_queue: small fifo between front and back
// Lets the front keep accepting while the back holds a stalled result.
// ----------------------------------------------------------------------------
`default_nettype none

module sosc_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire sosc_pkg::lookup_t push_data_i,
  input  wire logic              pop_i,
  output sosc_pkg::lookup_t      pop_data_o,
  output logic                   empty_o,
  output logic                   full_o
);
  import sosc_pkg::*;

  lookup_t                 mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntBits-1:0] cnt_q, cnt_d;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == QueueCntBits'(QueueDepth));
  assign pop_data_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QueueCntBits'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QueueCntBits'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= QueuePtrBits'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= QueuePtrBits'(rd_ptr_q + 1'b1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sosc_ctrl.sv
// ----------------------------------------------------------------------------
// sosc_ctrl: register file, gain ramp and step divider
// Holds the configuration, the ramp state, and a one-bit-per-cycle
// divider that forms the per-sample gain step after a new target.
// ----------------------------------------------------------------------------
`default_nettype none

module sosc_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sosc_pkg::apb_req_t             apb_i,
  output logic [sosc_pkg::ApbDataBits-1:0]    prdata_o,
  output logic [sosc_pkg::PhaseBits-1:0]      phase_inc_o,
  output logic                                busy_o,
  input  wire logic                           tick_i,
  output sosc_pkg::gain_t                     gain_o
);
  import sosc_pkg::*;

  localparam int DivCntBits = $clog2(PhaseBits);

  logic [PhaseBits-1:0]  phase_inc_q, phase_inc_d;
  logic [GainBits-1:0]   target_q, target_d;
  logic [RampBits-1:0]   ramp_len_q, ramp_len_d;
  logic [PhaseBits-1:0]  cur_q, cur_d;
  logic [PhaseBits:0]    step_q, step_d;
  logic [RampBits-1:0]   cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [DivCntBits-1:0] div_cnt_q, div_cnt_d;
  logic [RampBits-1:0]   rem_q, rem_d;
  logic [PhaseBits-1:0]  quo_q, quo_d;
  logic                  div_neg_q, div_neg_d;

  logic                  wr;
  reg_idx_e              widx;
  logic [GainBits-1:0]   t_raw, t_clamp;
  logic [PhaseBits-1:0]  tq31, new_q31, sum_next, g31, mag;
  logic [PhaseBits:0]    diff, neg_diff;
  logic [RampBits:0]     rem_shift, rem_sub;
  logic                  ge;
  logic [PhaseBits-1:0]  quo_new;

  assign wr    = apb_i.psel & apb_i.penable & apb_i.pwrite;
  assign widx  = reg_idx_e'(apb_i.paddr[ApbAddrBits-1:2]);

  // target clamp and distance to the new target
  assign t_raw    = apb_i.pwdata[GainBits-1:0];
  assign t_clamp  = (t_raw > GainBits'(GainOne)) ? GainBits'(GainOne) : t_raw;
  assign tq31     = {target_q, {(PhaseBits-GainBits){1'b0}}};
  assign new_q31  = {t_clamp, {(PhaseBits-GainBits){1'b0}}};
  assign diff     = {1'b0, new_q31} - {1'b0, cur_q};
  assign neg_diff = -diff;
  assign mag      = diff[PhaseBits] ? neg_diff[PhaseBits-1:0] : diff[PhaseBits-1:0];

  // restoring divide step
  assign rem_shift = {rem_q, quo_q[PhaseBits-1]};
  assign rem_sub   = rem_shift - {1'b0, ramp_len_q};
  assign ge        = (rem_shift >= {1'b0, ramp_len_q});
  assign quo_new   = {quo_q[PhaseBits-2:0], ge};

  // gain seen by the next sample
  assign sum_next = cur_q + step_q[PhaseBits-1:0];
  assign g31      = (cnt_q > RampBits'(1)) ? sum_next : tq31;
  assign gain_o.gain   = GainUseBits'({1'b0, g31[PhaseBits-1 -: GainBits]})
                       + GainUseBits'(g31[PhaseBits-GainBits-1]);
  assign gain_o.active = (cnt_q > RampBits'(1));

  assign phase_inc_o = phase_inc_q;
  assign busy_o      = busy_q;

  // register readback
  always_comb begin
    unique case (reg_idx_e'(apb_i.paddr[ApbAddrBits-1:2]))
      REG_PHASE_INC:   prdata_o = phase_inc_q;
      REG_TARGET_GAIN: prdata_o = ApbDataBits'(target_q);
      REG_RAMP_LENGTH: prdata_o = ApbDataBits'(ramp_len_q);
      default:         prdata_o = '0;
    endcase
  end

  // ramp advance, divider iteration, then register writes
  always_comb begin
    phase_inc_d = phase_inc_q;
    target_d    = target_q;
    ramp_len_d  = ramp_len_q;
    cur_d       = cur_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    div_cnt_d   = div_cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_neg_d   = div_neg_q;

    // one ramp tick per sample
    if (tick_i && cnt_q != '0) begin
      cnt_d = cnt_q - RampBits'(1);
      cur_d = (cnt_q != RampBits'(1)) ? sum_next : tq31;
    end

    // step division, one quotient bit per cycle
    if (busy_q) begin
      rem_d     = ge ? rem_sub[RampBits-1:0] : rem_shift[RampBits-1:0];
      quo_d     = quo_new;
      div_cnt_d = div_cnt_q + DivCntBits'(1);
      if (div_cnt_q == DivCntBits'(PhaseBits - 1)) begin
        busy_d = 1'b0;
        step_d = div_neg_q ? -{1'b0, quo_new} : {1'b0, quo_new};
      end
    end

    // configuration writes
    if (wr) begin
      unique case (widx)
        REG_PHASE_INC: begin
          phase_inc_d = apb_i.pwdata;
        end
        REG_TARGET_GAIN: begin
          if (t_clamp != target_q) begin
            target_d = t_clamp;
            if (ramp_len_q == '0) begin
              cur_d  = new_q31;
              cnt_d  = '0;
              step_d = '0;
              busy_d = 1'b0;
            end else begin
              cnt_d     = ramp_len_q;
              busy_d    = 1'b1;
              div_cnt_d = '0;
              rem_d     = '0;
              quo_d     = mag;
              div_neg_d = diff[PhaseBits];
            end
          end
        end
        REG_RAMP_LENGTH: begin
          ramp_len_d = apb_i.pwdata[RampBits-1:0];
          cur_d      = tq31;
          cnt_d      = '0;
          step_d     = '0;
          busy_d     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // control and ramp state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= '0;
      target_q    <= '0;
      ramp_len_q  <= RampBits'(480);
      cur_q       <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      phase_inc_q <= phase_inc_d;
      target_q    <= target_d;
      ramp_len_q  <= ramp_len_d;
      cur_q       <= cur_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    div_neg_q <= div_neg_d;
  end

endmodule

`default_nettype wire

FILE: rtl/sosc_back.sv
// ----------------------------------------------------------------------------
// sosc_back: table read, gain multiply, round and saturate
// Three-stage pipeline from queue pop to output register, all stages
// advancing together whenever the output register can move.
// ----------------------------------------------------------------------------
`default_nettype none

module sosc_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               q_empty_i,
  input  wire sosc_pkg::lookup_t                  q_data_i,
  output logic                                    pop_o,
  input  wire sosc_pkg::gain_t                    gain_i,
  input  wire logic                               out_stall_i,
  output logic                                    out_valid_o,
  output logic signed [sosc_pkg::SampleBits-1:0]  sample_o,
  output logic                                    ramp_active_o
);
  import sosc_pkg::*;

  localparam int     ProdBits   = SampleBits + GainUseBits + 1;
  localparam int     RndShift   = GainBits - 1;
  localparam int     RndBits    = ProdBits - RndShift;
  localparam int     RomDivBits = 40;
  localparam longint PiQ30      = 64'sd3373259426;

  typedef logic [SampleBits-1:0] sine_rom_t [TableSize];

  // shift-subtract quotient of two non-negative elaboration constants
  function automatic longint rom_div(longint num, longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = RomDivBits - 1; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | longint'(1);
      end
    end
    return quo;
  endfunction

  // quarter-wave table, Q30 series evaluated at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint    amp;
    longint    x;
    longint    x2;
    longint    term;
    longint    sum;
    amp = (longint'(1) <<< (SampleBits - 1)) - 1;
    for (int i = 0; i < TableSize; i++) begin
      x    = (PiQ30 * (2 * longint'(i) + 1)) >>> (TableAddrBits + 2);
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 9; k++) begin
        term = rom_div((term * x2) >>> 30, longint'((2 * k) * (2 * k + 1)));
        if ((k & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      rom[i] = SampleBits'((sum * amp + (longint'(1) <<< 29)) >>> 30);
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();
  localparam logic signed [RndBits-1:0] SatMax = RndBits'((1 <<< (SampleBits - 1)) - 1);
  localparam logic signed [RndBits-1:0] SatMin = ~SatMax;

  logic                          en;
  logic                          v1_q, v2_q, out_valid_q;
  logic [SampleBits-1:0]         rom_q;
  logic                          neg1_q;
  logic [GainUseBits-1:0]        gain1_q;
  logic                          act1_q, act2_q;
  logic signed [SampleBits-1:0]  s1;
  logic signed [ProdBits-1:0]    prod_q;
  logic signed [ProdBits-1:0]    prod_rnd;
  logic signed [RndBits-1:0]     rnd;
  logic signed [SampleBits-1:0]  sat;
  logic signed [SampleBits-1:0]  sample_q;
  logic                          active_q;

  // whole pipe moves when the output register is free or taken
  assign en    = ~out_valid_q | ~out_stall_i;
  assign pop_o = en & ~q_empty_i;

  // signed sine value and rounding
  assign s1       = neg1_q ? -$signed(rom_q) : $signed(rom_q);
  assign prod_rnd = prod_q + ProdBits'(1 <<< (RndShift - 1));
  assign rnd      = RndBits'(prod_rnd >>> RndShift);

  // saturate to sample width
  always_comb begin
    priority if (rnd > SatMax) begin
      sat = SampleBits'(SatMax);
    end else if (rnd < SatMin) begin
      sat = SampleBits'(SatMin);
    end else begin
      sat = SampleBits'(rnd);
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop_o;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // stage payloads: table read, multiply, output
  always_ff @(posedge clk_i) begin
    if (en) begin
      rom_q    <= SineRom[q_data_i.idx];
      neg1_q   <= q_data_i.neg;
      gain1_q  <= gain_i.gain;
      act1_q   <= gain_i.active;
      prod_q   <= s1 * $signed({1'b0, gain1_q});
      act2_q   <= act1_q;
      sample_q <= sat;
      active_q <= act2_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_o      = sample_q;
  assign ramp_active_o = active_q;

endmodule

`default_nettype wire

FILE: rtl/sine_oscillator_fm_gain_ramp.sv
// ----------------------------------------------------------------------------
// sine_oscillator_fm_gain_ramp: phase-modulated sine oscillator with gain ramp
// A beat goes through the queue, then the table, product and output registers.
// Throughput: one beat per cycle unless a full queue or step division stalls,
//   set by the phase add and the one table read and one multiply per sample.
// A target_gain write that changes the target with nonzero ramp_length stalls
//   input while the gain step is divided out one quotient bit per cycle.
// Reset: asynchronous, clears phase, gain, ramp and pipeline valids;
//   ramp_length resets to 480. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_oscillator_fm_gain_ramp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [sosc_pkg::PhaseBits-1:0] fm_offset_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [sosc_pkg::SampleBits-1:0]     sample_o,
  output logic                                       ramp_active_o,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [sosc_pkg::ApbAddrBits-1:0]      paddr,
  input  wire logic [sosc_pkg::ApbDataBits-1:0]      pwdata,
  output logic [sosc_pkg::ApbDataBits-1:0]           prdata,
  output logic                                       pready
);
  import sosc_pkg::*;

  apb_req_t             apb;
  logic [PhaseBits-1:0] phase_inc;
  logic                 busy;
  logic                 q_full, q_empty;
  logic                 push, pop;
  lookup_t              push_data, pop_data;
  gain_t                gain;

  assign apb.psel    = psel;
  assign apb.penable = penable;
  assign apb.pwrite  = pwrite;
  assign apb.paddr   = paddr;
  assign apb.pwdata  = pwdata;
  assign pready      = 1'b1;

  // registers and gain ramp
  sosc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .apb_i       (apb),
    .prdata_o    (prdata),
    .phase_inc_o (phase_inc),
    .busy_o      (busy),
    .tick_i      (pop),
    .gain_o      (gain)
  );

  // phase accumulator and classification
  sosc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .fm_offset_i (fm_offset_i),
    .in_stall_o  (in_stall_o),
    .phase_inc_i (phase_inc),
    .busy_i      (busy),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue
  sosc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // table, multiply, output
  sosc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .gain_i        (gain),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .sample_o      (sample_o),
    .ramp_active_o (ramp_active_o)
  );

endmodule

`default_nettype wire

FILE: rtl/sosc_checker.sv
// ----------------------------------------------------------------------------
// sosc_checker: port-level checks of the sine oscillator
// Watches the handshakes and the register port over time.
// ----------------------------------------------------------------------------
`default_nettype none

module sosc_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  in_valid_i,
  input wire logic                                  in_stall_o,
  input wire logic signed [sosc_pkg::PhaseBits-1:0] fm_offset_i,
  input wire logic                                  out_valid_o,
  input wire logic                                  out_stall_i,
  input wire logic signed [sosc_pkg::SampleBits-1:0] sample_o,
  input wire logic                                  ramp_active_o,
  input wire logic                                  psel,
  input wire logic                                  penable,
  input wire logic                                  pwrite,
  input wire logic [sosc_pkg::ApbAddrBits-1:0]      paddr,
  input wire logic [sosc_pkg::ApbDataBits-1:0]      pwdata,
  input wire logic [sosc_pkg::ApbDataBits-1:0]      prdata,
  input wire logic                                  pready
);
  import sosc_pkg::*;

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(fm_offset_i))
    else $error("stalled input beat changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(sample_o) && $stable(ramp_active_o))
    else $error("stalled result changed");

  // register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  // phase increment reads back what was just written
  a_wr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[ApbAddrBits-1:2] == REG_PHASE_INC) ##1
    (psel && !pwrite && paddr[ApbAddrBits-1:2] == REG_PHASE_INC) |->
      prdata == $past(pwdata))
    else $error("phase increment readback mismatch");

  // stored target is clamped to unity gain
  a_tgt_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && paddr[ApbAddrBits-1:2] == REG_TARGET_GAIN |->
      prdata <= ApbDataBits'(GainOne))
    else $error("target gain above unity");

endmodule

bind sine_oscillator_fm_gain_ramp sosc_checker u_sosc_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench of the phase-modulated sine oscillator with gain ramp
// Sends phase-offset beats in bursts to a sink that stalls, writes the
// registers over the APB port between phases, and checks every sample and
// ramp flag against a fixed-point model of the oscillator in a scoreboard.
// ---------------------------------------------------------------------------

module tb;
  import sosc_pkg::*;

  localparam int     CycleLimit  = 400000;
  localparam int     RandomBeats = 1400;
  localparam int     ReportLimit = 20;
  localparam longint PiQ30       = 64'sd3373259426;
  localparam longint SampleMax   = (64'sd1 <<< (SampleBits - 1)) - 1;
  localparam longint SampleMin   = -(64'sd1 <<< (SampleBits - 1));

  localparam logic [31:0] CornerOffsets [9] = '{
    32'h0000_0000, 32'h0010_0000, 32'h3FF0_0000, 32'h4000_0000, 32'h7FFF_FFFF,
    32'h8000_0000, 32'hBFFF_FFFF, 32'hC000_0000, 32'hFFFF_FFFF
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_e;

  // one output beat: scaled sine value and ramp flag
  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         active;
  } tone_t;

  // fixed-point oscillator model and queue of expected tones
  class tone_scoreboard;
    int        sine_rom [TableSize];
    bit [31:0] phase_inc;
    bit [15:0] target;
    bit [15:0] ramp_len;
    bit [31:0] phase;
    bit [31:0] gain_q31;
    longint    gain_step;
    bit [15:0] countdown;
    int        errors;
    tone_t     pending_tones [$];

    function new();
      longint x, x2, term, sum;
      // quarter-wave table from a Q30 Taylor series
      for (int i = 0; i < TableSize; i++) begin
        x = (PiQ30 * longint'(2 * i + 1)) / longint'(4 * TableSize);
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 9; k++) begin
          term = ((term * x2) >>> 30) / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) sum -= term;
          else sum += term;
        end
        if (sum < 0) sum = 0;
        sine_rom[i] = int'((sum * SampleMax + (64'sd1 <<< 29)) >>> 30);
      end
      phase_inc = '0;
      target    = '0;
      ramp_len  = 16'd480;
      phase     = '0;
      gain_q31  = '0;
      gain_step = 0;
      countdown = '0;
      errors    = 0;
    endfunction

    function void write_reg(reg_idx_e idx, bit [31:0] data);
      bit [15:0] t;
      case (idx)
        REG_PHASE_INC: phase_inc = data;
        REG_TARGET_GAIN: begin
          t = data[15:0];
          if (t > GainOne) t = GainOne;
          // rewriting the held target leaves the ramp alone
          if (t != target) begin
            target = t;
            if (ramp_len == 0) begin
              gain_q31  = {t, 16'h0};
              countdown = '0;
              gain_step = 0;
            end else begin
              countdown = ramp_len;
              gain_step = (longint'({t, 16'h0}) - longint'(gain_q31)) / longint'(ramp_len);
            end
          end
        end
        REG_RAMP_LENGTH: begin
          // stops the ramp and snaps to the target
          ramp_len  = data[15:0];
          gain_q31  = {target, 16'h0};
          countdown = '0;
          gain_step = 0;
        end
        default: ;
      endcase
    endfunction

    function void note_offset(bit [31:0] offset);
      bit [31:0]              p;
      bit [TableAddrBits-1:0] idx;
      bit [31:0]              gain_used;
      longint                 s, g, prod, q;
      tone_t                  tone;
      // table read at phase plus offset, mirrored and negated by quadrant
      p = phase + offset;
      idx = p[29 -: TableAddrBits];
      if (p[30]) idx = ~idx;
      s = sine_rom[idx];
      if (p[31]) s = -s;
      phase += phase_inc;
      // advance the ramp, last tick lands exactly on the target
      if (countdown == 0) begin
        gain_used = {target, 16'h0};
      end else begin
        countdown--;
        if (countdown != 0) gain_q31 = gain_q31 + gain_step[31:0];
        else gain_q31 = {target, 16'h0};
        gain_used = gain_q31;
      end
      g = (longint'(gain_used) + 32768) >>> 16;
      prod = s * g;
      q = (prod + 16384) >>> 15;
      if (q > SampleMax) q = SampleMax;
      if (q < SampleMin) q = SampleMin;
      tone.sample = q[SampleBits-1:0];
      tone.active = (countdown != 0);
      pending_tones.push_back(tone);
    endfunction

    function void check_tone(logic signed [SampleBits-1:0] smp, logic act);
      tone_t want;
      if (pending_tones.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: unexpected beat, sample %0d ramp %b", $time, smp, act);
        return;
      end
      want = pending_tones.pop_front();
      if (smp !== want.sample) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: sample expected %0d got %0d", $time, want.sample, smp);
      end
      if (act !== want.active) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: ramp_active expected %b got %b", $time, want.active, act);
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [PhaseBits-1:0]   fm_offset_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [SampleBits-1:0]  sample_o;
  logic                          ramp_active_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ApbAddrBits-1:0]        paddr;
  logic [ApbDataBits-1:0]        pwdata;
  logic [ApbDataBits-1:0]        prdata;
  logic                          pready;

  stall_pattern_e stall_pattern = STALL_NONE;
  int             stall_tick = 0;
  int             cycle_count = 0;
  tone_scoreboard board;

  sine_oscillator_fm_gain_ramp i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .fm_offset_i   (fm_offset_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_o      (sample_o),
    .ramp_active_o (ramp_active_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sine_oscillator_fm_gain_ramp: mismatch");
      $finish;
    end
  end

  // sink stall, independent of the sender
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    case (stall_pattern)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_SPARSE: out_stall_i <= ($urandom_range(0, 4) == 0);
      STALL_HEAVY:  out_stall_i <= ($urandom_range(0, 1) == 0);
      default:      out_stall_i <= ((stall_tick % 8) < 3);
    endcase
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_tone(sample_o, ramp_active_o);
  end

  // setup and access phases, then idle with psel low
  task automatic reg_write(reg_idx_e idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.write_reg(idx, data);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // one input beat, held until accepted
  task automatic send_offset(logic [31:0] offset);
    in_valid_i  <= 1'b1;
    fm_offset_i <= offset;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_offset(offset);
    @(negedge clk_i);
  endtask

  task automatic sender_gap(int cycles);
    in_valid_i  <= 1'b0;
    fm_offset_i <= $urandom;
    repeat (cycles) @(negedge clk_i);
  endtask

  // hold the sender until every expected tone is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_tones.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'h0;
      3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4, 5:    return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_increment();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(1, 32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_ramp_length();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF;
      3:       return $urandom_range(0, 32'hFFFF);
      4, 5:    return $urandom_range(65, 400);
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  function automatic logic [31:0] pick_target();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return GainOne;
      2:       return $urandom_range(GainOne + 1, 32'hFFFF);
      3:       return board.target;
      default: return $urandom_range(0, GainOne);
    endcase
  endfunction

  initial begin
    int sent;
    int burst_left;
    int phase_beats;
    bit bursty;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    fm_offset_i = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    sent        = 0;
    board       = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // unity gain at once, table corners and quadrant boundaries
    reg_write(REG_RAMP_LENGTH, 32'd0);
    reg_write(REG_TARGET_GAIN, GainOne);
    for (int i = 0; i < 9; i++) send_offset(CornerOffsets[i]);

    // target above one clamps to one, which is already held
    wait_drained();
    reg_write(REG_TARGET_GAIN, 32'h0000_FFFF);
    send_offset(32'h2000_0000);

    // short falling ramp, through its last tick
    wait_drained();
    reg_write(REG_RAMP_LENGTH, 32'd4);
    reg_write(REG_TARGET_GAIN, 32'd100);
    repeat (6) send_offset($urandom);

    // full-turn increment with a rising ramp, then a length write snaps it
    wait_drained();
    reg_write(REG_PHASE_INC, 32'hFFFF_FFFF);
    reg_write(REG_TARGET_GAIN, GainOne);
    repeat (2) send_offset(32'h0);
    wait_drained();
    reg_write(REG_RAMP_LENGTH, 32'h0000_FFFF);
    repeat (2) send_offset(32'h0);

    // longest ramp toward zero
    wait_drained();
    reg_write(REG_TARGET_GAIN, 32'd0);
    repeat (2) send_offset($urandom);

    // random phases, each with its own settings, stall pattern and burstiness
    while (sent < RandomBeats) begin
      wait_drained();
      stall_pattern <= stall_pattern_e'($urandom_range(0, 3));
      bursty = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) reg_write(REG_PHASE_INC, pick_increment());
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 1) == 0) reg_write(REG_RAMP_LENGTH, pick_ramp_length());
        reg_write(REG_TARGET_GAIN, pick_target());
      end else begin
        if ($urandom_range(0, 2) == 0) reg_write(REG_TARGET_GAIN, pick_target());
        if ($urandom_range(0, 2) == 0) reg_write(REG_RAMP_LENGTH, pick_ramp_length());
      end
      phase_beats = $urandom_range(20, 120);
      burst_left = $urandom_range(1, 16);
      repeat (phase_beats) begin
        if (bursty && burst_left <= 0) begin
          sender_gap($urandom_range(1, 6));
          burst_left = $urandom_range(1, 16);
        end
        if ($urandom_range(0, 199) == 0) wait_drained();
        send_offset(pick_offset());
        burst_left--;
        sent++;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) $display("sine_oscillator_fm_gain_ramp: match");
    else $display("sine_oscillator_fm_gain_ramp: mismatch");
    $finish;
  end

endmodule
